FILE: hw/rtl/tpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpp_pkg
// shared constants for the twisted pipe point evaluator: angle and output
// formats, sine polynomial coefficients and unit latencies
// ----------------------------------------------------------------------------
package tpp_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 13;

    // q30 unity
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // odd taylor terms of sin(pi/2 * t), q30
    localparam logic [30:0] COEF_A9 = 31'd172272;
    localparam logic [30:0] HORNER_COEF [4] = '{
        31'd5026995,
        31'd85569306,
        31'd693598669,
        31'd1686629713
    };

    localparam int SIN_LAT = 6;
    localparam int QUO_BITS = 32;
    localparam int DIV_LAT  = QUO_BITS + 1;

endpackage : tpp_pkg
`default_nettype wire

FILE: hw/rtl/tpp_sine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpp_sine
// pipelined q30 sine of a binary angle, magnitude and sign, six stages
// ----------------------------------------------------------------------------
module tpp_sine
    import tpp_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic [30:0]           mag,
    output logic                  neg
);

    logic [29:0] f;
    logic [30:0] t;
    logic [61:0] tt;

    logic [30:0] t_reg   [0:4];
    logic [30:0] t2_reg  [0:3];
    logic        neg_reg [0:4];
    logic [30:0] r_reg   [1:4];
    logic [30:0] mag_reg;
    logic        sgn_reg;
    logic [61:0] fin_prod;
    logic [31:0] fin_s;

    // fraction of the quadrant, mirrored in odd quadrants
    assign f  = {angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
    assign t  = angle[ANGLE_BITS-2] ? (ONE_Q30 - {1'b0, f}) : {1'b0, f};
    assign tt = 62'(t) * 62'(t);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0]   <= t;
            t2_reg[0]  <= tt[60:30];
            neg_reg[0] <= angle[ANGLE_BITS-1];
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_horner
        logic [30:0] r_in;
        logic [61:0] prod;
        if (k == 0)
        begin : g_first
            assign r_in = COEF_A9;
        end
        else
        begin : g_next
            assign r_in = r_reg[k];
        end
        assign prod = 62'(t2_reg[k]) * 62'(r_in);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k+1]   <= HORNER_COEF[k] - prod[60:30];
                t_reg[k+1]   <= t_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
        if (k < 3)
        begin : g_t2
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    t2_reg[k+1] <= t2_reg[k];
                end
            end
        end
    end

    assign fin_prod = 62'(t_reg[4]) * 62'(r_reg[4]);
    assign fin_s    = fin_prod[61:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= (fin_s > 32'(ONE_Q30)) ? ONE_Q30 : fin_s[30:0];
            sgn_reg <= neg_reg[4];
        end
    end

    assign mag = mag_reg;
    assign neg = sgn_reg;

endmodule : tpp_sine
`default_nettype wire

FILE: hw/rtl/tpp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpp_div
// pipelined rounded q60 / q30 divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module tpp_div
    import tpp_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [61:0]         num,
    input  logic [30:0]         den,
    output logic [QUO_BITS-1:0] quo
);

    logic [62:0]         n_sum;
    logic [30:0]         rem_reg [0:QUO_BITS-1];
    logic [31:0]         low_reg [0:QUO_BITS-1];
    logic [30:0]         den_reg [0:QUO_BITS-1];
    logic [QUO_BITS-1:0] quo_reg [0:QUO_BITS];

    // round to nearest by adding half the divisor
    assign n_sum = {1'b0, num} + 63'(den >> 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= n_sum[62:32];
            low_reg[0] <= n_sum[31:0];
            den_reg[0] <= den;
            quo_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_step
        logic [31:0] r2;
        logic [31:0] diff;
        logic        ge;
        assign r2   = {rem_reg[i], low_reg[i][31]};
        assign ge   = (r2 >= {1'b0, den_reg[i]});
        assign diff = r2 - {1'b0, den_reg[i]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[i+1] <= {quo_reg[i][QUO_BITS-2:0], ge};
            end
        end
        if (i < QUO_BITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1] <= ge ? diff[30:0] : r2[30:0];
                    low_reg[i+1] <= {low_reg[i][30:0], 1'b0};
                    den_reg[i+1] <= den_reg[i];
                end
            end
        end
    end

    assign quo = quo_reg[QUO_BITS];

endmodule : tpp_div
`default_nettype wire

FILE: hw/rtl/twisted_pipe_point_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twisted_pipe_point_eval
// evaluates a point of the twisted pipe surface from a (u, v) angle pair
// ----------------------------------------------------------------------------
// throughput: one word per cycle unless the output holds; six-stage sine
// pipes, a 31-stage square root and 33-stage dividers, all stepping together
// the whole pipeline holds when the output word waits
// reset clears the valid bits only; no clearing pass
module twisted_pipe_point_eval
    import tpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // u_angle [15:0], v_angle [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // x_coord [15:0], y_coord [31:16], z_coord [47:32]
);

    localparam int SQ_N  = 31;
    localparam int DEPTH = SIN_LAT + 1 + SQ_N + DIV_LAT + 1;
    localparam int NEG_N = SQ_N + DIV_LAT;

    localparam logic [ANGLE_BITS-1:0] THIRD   = ANGLE_BITS'((1 << ANGLE_BITS) / 3);
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1 << (ANGLE_BITS - 2));
    localparam logic [32:0] RND = 33'(1) << (29 - FRAC_BITS);
    localparam logic [32:0] LIM = 33'(3) << FRAC_BITS;

    logic en;
    logic vld_reg [0:DEPTH-1];

    // whole pipe advances while the output slot is free or being taken
    assign en       = !vld_reg[DEPTH-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // angle set: sin v, cos v, sin(v-T), sin(v+T), cos u, cos(u-T), cos(u+T)
    logic [ANGLE_BITS-1:0] u_a;
    logic [ANGLE_BITS-1:0] v_a;
    logic [ANGLE_BITS-1:0] ang [7];
    logic [30:0]           smag [7];
    logic                  sneg [7];

    assign u_a    = s_tdata[ANGLE_BITS-1:0];
    assign v_a    = s_tdata[16 + ANGLE_BITS - 1:16];
    assign ang[0] = v_a;
    assign ang[1] = v_a + QUARTER;
    assign ang[2] = v_a - THIRD;
    assign ang[3] = v_a + THIRD;
    assign ang[4] = u_a + QUARTER;
    assign ang[5] = u_a - THIRD + QUARTER;
    assign ang[6] = u_a + THIRD + QUARTER;

    for (genvar s = 0; s < 7; s++)
    begin : g_sin
        tpp_sine u_sine
        (
            .clk   (clk),
            .en    (en),
            .angle (ang[s]),
            .mag   (smag[s]),
            .neg   (sneg[s])
        );
    end

    // numerators and the radicand 1 + sin(v)^2
    logic [31:0] fac [3];
    logic [62:0] nprod [3];
    logic [61:0] sq;

    for (genvar c = 0; c < 3; c++)
    begin : g_num
        assign fac[c]   = sneg[4 + c] ? (32'h8000_0000 - 32'(smag[4 + c]))
                                      : (32'h8000_0000 + 32'(smag[4 + c]));
        assign nprod[c] = 63'(smag[1 + c]) * 63'(fac[c]);
    end
    assign sq = 62'(smag[0]) * 62'(smag[0]);

    logic [61:0] num_reg [0:SQ_N][3];
    logic [2:0]  neg_reg [0:NEG_N];
    logic [61:0] sx_reg  [0:SQ_N-1];
    logic [61:0] sr_reg  [0:SQ_N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                num_reg[0][c] <= nprod[c][61:0];
            end
            neg_reg[0] <= {sneg[3], sneg[2], sneg[1]};
            sx_reg[0]  <= (62'(1) << 60) + sq;
            sr_reg[0]  <= '0;
            for (int i = 1; i <= SQ_N; i++)
            begin
                num_reg[i] <= num_reg[i-1];
            end
            for (int i = 1; i <= NEG_N; i++)
            begin
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    // bit-serial square root, radicand never below 2^60
    for (genvar i = 0; i < SQ_N; i++)
    begin : g_sqrt
        localparam logic [61:0] BIT = 62'(1) << (60 - 2 * i);
        logic [61:0] trial;
        logic        ge;
        assign trial = sr_reg[i] + BIT;
        assign ge    = (sx_reg[i] >= trial);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sr_reg[i+1] <= ge ? ((sr_reg[i] >> 1) + BIT) : (sr_reg[i] >> 1);
            end
        end
        if (i < SQ_N - 1)
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sx_reg[i+1] <= ge ? (sx_reg[i] - trial) : sx_reg[i];
                end
            end
        end
    end

    logic [QUO_BITS-1:0] quo [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        tpp_div u_div
        (
            .clk (clk),
            .en  (en),
            .num (num_reg[SQ_N][c]),
            .den (sr_reg[SQ_N][30:0]),
            .quo (quo[c])
        );
    end

    // round to output format, saturate, apply sign
    function automatic logic [15:0] to_coord(input logic [QUO_BITS-1:0] q, input logic n);
        logic [32:0] rs;
        logic [32:0] qf;
        logic [32:0] val;
        rs  = {1'b0, q} + RND;
        qf  = rs >> (30 - FRAC_BITS);
        if (qf > LIM)
        begin
            qf = LIM;
        end
        val = n ? (33'd0 - qf) : qf;
        return val[15:0];
    endfunction

    logic [47:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= {to_coord(quo[2], neg_reg[NEG_N][2]),
                        to_coord(quo[1], neg_reg[NEG_N][1]),
                        to_coord(quo[0], neg_reg[NEG_N][0])};
        end
    end

    assign m_tdata = out_reg;

endmodule : twisted_pipe_point_eval
`default_nettype wire

FILE: dv/tpp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_checker
// watches both stream channels of the twisted pipe point evaluator, predicts
// each point from the accepted (u, v) word and compares it with the output
// ----------------------------------------------------------------------------
module tpp_checker
    import tpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          pending,
    output int          fail_count
);

    localparam logic [31:0] THIRD_TURN = 32'((64'd1 << ANGLE_BITS) / 3);
    localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 1);
    localparam logic [63:0] Q30 = 64'd1 << 30;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } point_t;

    point_t expected_points[$];

    function automatic logic [63:0] quarter_sin(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] r;
        t2 = (t * t) >> 30;
        r  = 64'(COEF_A9);
        for (int k = 0; k < 4; k++)
            r = 64'(HORNER_COEF[k]) - ((t2 * r) >> 30);
        r = (t * r) >> 30;
        return (r > Q30) ? Q30 : r;
    endfunction

    // q30 sine magnitude of a 32-bit phase, sign on the side
    function automatic logic [63:0] phase_sin(input logic [31:0] p, output logic neg);
        logic [63:0] f;
        f   = {34'd0, p[29:0]};
        neg = p[31];
        return quarter_sin(p[30] ? (Q30 - f) : f);
    endfunction

    function automatic logic [31:0] to_phase(input logic [31:0] a);
        return (a & ANGLE_MASK) << (32 - ANGLE_BITS);
    endfunction

    function automatic logic [63:0] two_plus_cos(input logic [31:0] a);
        logic        neg;
        logic [63:0] c;
        c = phase_sin(to_phase(a) + 32'h4000_0000, neg);
        return neg ? (2 * Q30 - c) : (2 * Q30 + c);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] scaled_coord(input logic [63:0] mag, input logic neg,
                                                 input logic [63:0] fac, input logic [63:0] h);
        logic [63:0] q30v;
        logic [63:0] qf;
        logic [63:0] lim;
        q30v = (mag * fac + (h >> 1)) / h;
        qf   = (q30v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        lim  = 64'd3 << FRAC_BITS;
        if (qf > lim)
            qf = lim;
        return neg ? 16'(-qf) : 16'(qf);
    endfunction

    function automatic point_t surface_point(input logic [31:0] u, input logic [31:0] v);
        logic        neg;
        logic [63:0] sv;
        logic [63:0] h;
        logic [63:0] trig;
        point_t      pt;
        u    = u & ANGLE_MASK;
        v    = v & ANGLE_MASK;
        sv   = phase_sin(to_phase(v), neg);
        h    = int_sqrt((Q30 << 30) + sv * sv);
        trig = phase_sin(to_phase(v) + 32'h4000_0000, neg);
        pt.x = scaled_coord(trig, neg, two_plus_cos(u), h);
        // offset angles wrap around the full turn
        trig = phase_sin(to_phase((v - THIRD_TURN) & ANGLE_MASK), neg);
        pt.y = scaled_coord(trig, neg, two_plus_cos((u - THIRD_TURN) & ANGLE_MASK), h);
        trig = phase_sin(to_phase((v + THIRD_TURN) & ANGLE_MASK), neg);
        pt.z = scaled_coord(trig, neg, two_plus_cos((u + THIRD_TURN) & ANGLE_MASK), h);
        return pt;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    initial
    begin
        pending    = 0;
        fail_count = 0;
    end

    always @(posedge clk)
    begin
        point_t want;
        point_t got;
        if (rst_n && s_tvalid && s_tready)
            expected_points.push_back(surface_point({16'd0, s_tdata[15:0]},
                                                    {16'd0, s_tdata[31:16]}));
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_points.size() == 0)
                report_mismatch($sformatf("unexpected point %h", m_tdata));
            else
            begin
                want = expected_points.pop_front();
                if (got.x !== want.x)
                    report_mismatch($sformatf("x got %h want %h", got.x, want.x));
                if (got.y !== want.y)
                    report_mismatch($sformatf("y got %h want %h", got.y, want.y));
                if (got.z !== want.z)
                    report_mismatch($sformatf("z got %h want %h", got.z, want.z));
            end
        end
        pending <= expected_points.size();
    end

endmodule : tpp_checker

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the twisted pipe point evaluator: directed angle
// corners, then random (u, v) words under three idling patterns
// ----------------------------------------------------------------------------
module tb_top;

    import tpp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // u_angle [15:0], v_angle [31:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // x_coord [15:0], y_coord [31:16], z_coord [47:32]

    int pending;
    int fail_count;
    int tx_idle_pct = 0;  // chance of a gap before each input word
    int rx_idle_pct = 0;  // chance of holding off an output word

    localparam int PIPE_DRAIN = 200;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    twisted_pipe_point_eval u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tpp_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // receiver back-pressure, one decision per cycle
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    // one word onto the input channel, with random gaps in front of it
    task automatic send_angles(input logic [15:0] u, input logic [15:0] v);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, u};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // angles near the quarter and third turns hit the zero and peak factors
    function automatic logic [15:0] pick_angle();
        logic [15:0] anchors [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                     16'd21845, 16'd43690, 16'd10923, 16'hFFFF};
        if ($urandom_range(3) == 0)
            return anchors[$urandom_range(7)] + 16'($signed($urandom_range(8)) - 4);
        return 16'($urandom());
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            send_angles(pick_angle(), pick_angle());
    endtask

    initial
    begin
        logic [15:0] corners [10] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
                                      16'd21845, 16'd43690, 16'h5555, 16'hAAAA, 16'h0001};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed corners: extremes, quarter turns, third-turn offsets that
        // wrap, zero cos(v) for x and zero trig factors for y and z
        for (int i = 0; i < 10; i++)
            send_angles(corners[i], corners[i]);
        for (int i = 0; i < 10; i++)
            send_angles(corners[9 - i], corners[(i * 3) % 10]);

        tx_idle_pct = 31;
        rx_idle_pct = 74;
        random_phase(360);

        // hold the sender until the pipeline has emptied
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);

        tx_idle_pct = 74;
        rx_idle_pct = 31;
        random_phase(360);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(360);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);

        if (fail_count == 0)
            $display("twisted_pipe_point_eval test passed");
        else
            $display("twisted_pipe_point_eval test failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2ms;
        $display("twisted_pipe_point_eval test failed");
        $finish;
    end

endmodule : tb_top

FILE: twisted_pipe_point_eval.f
hw/rtl/tpp_pkg.sv
hw/rtl/tpp_sine.sv
hw/rtl/tpp_div.sv
hw/rtl/twisted_pipe_point_eval.sv
dv/tpp_checker.sv
dv/tb_top.sv
